/* design/tss_pkg.sv */
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants of the tcp send sequence tracker
// Command codes, register indexes and the word formats of the request, the
// decoded command word and the result.
// ----------------------------------------------------------------------------
package tss_pkg;

   localparam int CMD_W = 3;
   localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_TRANSMIT   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SEND_SYN   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEND_FIN   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PEER_ACK   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SEND_ACK   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SEND_RESET = 3'd6;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SEGMENT_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_PORT       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REMOTE_PORT      = 2'd2;

   localparam int MSS_W   = 11;
   localparam int COUNT_W = 13;
   localparam logic [MSS_W-1:0] MSS_RESET         = 11'd536;
   localparam logic [15:0]      ADVERTISED_WINDOW = 16'd1024;

   // depth of the queues between the front, the back and the result port
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [2:0]  command;
      logic [12:0] write_length;
      logic [31:0] peer_ack_number;
      logic        peer_ack_set;
      logic [31:0] peer_seq_number;
      logic [15:0] peer_seq_length;
      logic [15:0] peer_source_port;
      logic [15:0] peer_dest_port;
      logic [31:0] receive_next;
      logic        peer_isn_known;
   } tss_req_type;

   // decoded command word; the reset header is prebuilt by the front
   typedef struct packed {
      logic [2:0]  command;
      logic [12:0] write_length;
      logic [31:0] peer_ack_number;
      logic [31:0] receive_next;
      logic        peer_isn_known;
      logic [15:0] rst_source_port;
      logic [15:0] rst_dest_port;
      logic [31:0] rst_seq_number;
      logic [31:0] rst_ack_number;
      logic        rst_ack_flag;
   } tss_op_type;

   typedef struct packed {
      logic        segment_valid;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [31:0] seq_number;
      logic [31:0] ack_number;
      logic        syn_flag;
      logic        ack_flag;
      logic        fin_flag;
      logic        rst_flag;
      logic [15:0] window_size;
      logic [12:0] payload_offset;
      logic [12:0] byte_count;
   } tss_rsp_type;

endpackage

/* design/tss_queue.sv */
// ----------------------------------------------------------------------------
// tss_queue: short first-in first-out queue
// Holds words between the front and the back, and results for the port.
// ----------------------------------------------------------------------------
module tss_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int DEPTH   = tss_pkg::QUEUE_DEPTH;
   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

   logic [WIDTH-1:0]   mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue occupancy above its depth");
`endif

endmodule

/* design/tss_front.sv */
// ----------------------------------------------------------------------------
// tss_front: request intake and classification
// Takes request words into the command queue, keeps only what the back
// needs and prebuilds the header of a reset answer, which needs no state.
// ----------------------------------------------------------------------------
module tss_front (
   input  logic                 req_push,
   input  tss_pkg::tss_req_type req_data,
   output logic                 req_full,
   output logic                 op_push,
   output tss_pkg::tss_op_type  op_word,
   input  logic                 op_full
);

   assign req_full = op_full;
   assign op_push  = req_push;

   always_comb begin
      op_word                 = '0;
      op_word.command         = req_data.command;
      op_word.write_length    = req_data.write_length;
      op_word.peer_ack_number = req_data.peer_ack_number;
      op_word.receive_next    = req_data.receive_next;
      op_word.peer_isn_known  = req_data.peer_isn_known;
      // reset answer: ports swapped, seq or ack taken from the peer segment
      op_word.rst_source_port = req_data.peer_dest_port;
      op_word.rst_dest_port   = req_data.peer_source_port;
      if (req_data.peer_ack_set) begin
         op_word.rst_seq_number = req_data.peer_ack_number;
         op_word.rst_ack_number = '0;
         op_word.rst_ack_flag   = 1'b0;
      end else begin
         op_word.rst_seq_number = '0;
         op_word.rst_ack_number = req_data.peer_seq_number
                                  + 32'(req_data.peer_seq_length);
         op_word.rst_ack_flag   = 1'b1;
      end
   end

endmodule

/* design/tss_back.sv */
// ----------------------------------------------------------------------------
// tss_back: sequence state and command execution
// Holds the send sequence state and the registers, runs one command word a
// cycle while the result queue is not full and builds its result word.
// ----------------------------------------------------------------------------
module tss_back #(
   parameter int SEND_BUFFER_BYTES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tss_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                op_empty,
   input  tss_pkg::tss_op_type                 op_word,
   output logic                                op_pop,
   input  logic                                res_full,
   output logic                                res_push,
   output tss_pkg::tss_rsp_type                res_word
);

   localparam int FW = $clog2(SEND_BUFFER_BYTES + 1);
   localparam int CW = (FW > tss_pkg::COUNT_W) ? FW : tss_pkg::COUNT_W;
   localparam logic [FW-1:0] BUF_BYTES = FW'(SEND_BUFFER_BYTES);

   logic [31:0]               una_ff, una_in;
   logic [31:0]               nxt_ff, nxt_in;
   logic [FW-1:0]             fill_ff, fill_in;
   logic                      syn_ff, syn_in;
   logic                      fin_ff, fin_in;
   logic [tss_pkg::MSS_W-1:0] mss_ff, mss_in;
   logic [15:0]               lport_ff, lport_in;
   logic [15:0]               rport_ff, rport_in;

   // write
   logic [CW-1:0] space_c, take_c;
   // transmit
   logic          syn_eff, fin_eff;
   logic [31:0]   offset;
   logic          no_data;
   logic [CW-1:0] rest_c, len_c;
   logic [tss_pkg::MSS_W-1:0] len;
   logic [31:0]   tx_advance;
   // peer ack
   logic [31:0]   una_syn, acked, unacked, newly;
   logic          use_unacked, ack_pos, ack_excess;

   assign op_pop   = !op_empty && !res_full;
   assign res_push = op_pop;

   assign space_c = CW'(BUF_BYTES - fill_ff);
   assign take_c  = (CW'(op_word.write_length) < space_c) ? CW'(op_word.write_length)
                                                           : space_c;

   assign syn_eff    = syn_ff | (op_word.command == tss_pkg::CMD_SEND_SYN);
   assign fin_eff    = fin_ff | (op_word.command == tss_pkg::CMD_SEND_FIN);
   assign offset     = nxt_ff - una_ff;
   assign no_data    = offset > 32'(fill_ff);
   assign rest_c     = CW'(fill_ff - offset[FW-1:0]);
   assign len_c      = (rest_c > CW'(mss_ff)) ? CW'(mss_ff) : rest_c;
   assign len        = len_c[tss_pkg::MSS_W-1:0];
   assign tx_advance = 32'(syn_eff) + 32'(fin_eff) + 32'(len);

   // a pending syn counts as acked before the ack amount is worked out
   assign una_syn     = una_ff + 32'(syn_ff);
   assign acked       = op_word.peer_ack_number - una_syn;
   assign unacked     = nxt_ff - una_syn;
   assign use_unacked = $signed(acked) > $signed(unacked);
   assign newly       = use_unacked ? unacked : acked;
   assign ack_pos     = !newly[31] && (newly != '0);
   assign ack_excess  = newly > 32'(fill_ff);

   always_comb begin
      una_in   = una_ff;
      nxt_in   = nxt_ff;
      fill_in  = fill_ff;
      syn_in   = syn_ff;
      fin_in   = fin_ff;
      res_word = '0;
      if (op_pop) begin
         unique case (op_word.command) inside
            tss_pkg::CMD_WRITE: begin
               fill_in             = fill_ff + take_c[FW-1:0];
               res_word.byte_count = take_c[tss_pkg::COUNT_W-1:0];
            end
            tss_pkg::CMD_TRANSMIT, tss_pkg::CMD_SEND_SYN, tss_pkg::CMD_SEND_FIN: begin
               syn_in = syn_eff;
               fin_in = fin_eff;
               if (!no_data) begin
                  res_word.segment_valid  = 1'b1;
                  res_word.source_port    = lport_ff;
                  res_word.dest_port      = rport_ff;
                  res_word.seq_number     = nxt_ff;
                  res_word.ack_number     = op_word.receive_next;
                  res_word.syn_flag       = syn_eff;
                  res_word.ack_flag       = op_word.peer_isn_known;
                  res_word.fin_flag       = fin_eff;
                  res_word.window_size    = tss_pkg::ADVERTISED_WINDOW;
                  res_word.payload_offset = offset[tss_pkg::COUNT_W-1:0];
                  res_word.byte_count     = tss_pkg::COUNT_W'(len);
                  nxt_in                  = nxt_ff + tx_advance;
               end
            end
            tss_pkg::CMD_PEER_ACK: begin
               syn_in = 1'b0;
               una_in = una_syn;
               if (ack_pos) begin
                  // una + newly lands on either send_next or the peer ack
                  una_in = use_unacked ? nxt_ff : op_word.peer_ack_number;
                  if (ack_excess) begin
                     fill_in = '0;
                     fin_in  = 1'b0;
                  end else begin
                     fill_in = fill_ff - newly[FW-1:0];
                  end
               end
            end
            tss_pkg::CMD_SEND_ACK: begin
               res_word.segment_valid = 1'b1;
               res_word.source_port   = lport_ff;
               res_word.dest_port     = rport_ff;
               res_word.seq_number    = nxt_ff;
               res_word.ack_number    = op_word.receive_next;
               res_word.ack_flag      = 1'b1;
               res_word.window_size   = tss_pkg::ADVERTISED_WINDOW;
            end
            tss_pkg::CMD_SEND_RESET: begin
               res_word.segment_valid = 1'b1;
               res_word.source_port   = op_word.rst_source_port;
               res_word.dest_port     = op_word.rst_dest_port;
               res_word.seq_number    = op_word.rst_seq_number;
               res_word.ack_number    = op_word.rst_ack_number;
               res_word.ack_flag      = op_word.rst_ack_flag;
               res_word.rst_flag      = 1'b1;
            end
            default: begin
               res_word = '0;
            end
         endcase
      end
   end

   always_comb begin
      mss_in   = mss_ff;
      lport_in = lport_ff;
      rport_in = rport_ff;
      if (csr_we) begin
         unique case (csr_index)
            tss_pkg::CSR_MAX_SEGMENT_SIZE: mss_in   = csr_wdata[tss_pkg::MSS_W-1:0];
            tss_pkg::CSR_LOCAL_PORT:       lport_in = csr_wdata;
            tss_pkg::CSR_REMOTE_PORT:      rport_in = csr_wdata;
            default: begin
               mss_in = mss_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         una_ff   <= '0;
         nxt_ff   <= '0;
         fill_ff  <= '0;
         syn_ff   <= 1'b0;
         fin_ff   <= 1'b0;
         mss_ff   <= tss_pkg::MSS_RESET;
         lport_ff <= '0;
         rport_ff <= '0;
      end else begin
         una_ff   <= una_in;
         nxt_ff   <= nxt_in;
         fill_ff  <= fill_in;
         syn_ff   <= syn_in;
         fin_ff   <= fin_in;
         mss_ff   <= mss_in;
         lport_ff <= lport_in;
         rport_ff <= rport_in;
      end
   end

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= BUF_BYTES)
      else $error("send buffer fill above its size");

   a_nxt_only_on_tx: assert property (@(posedge clock) disable iff (reset)
      !(op_pop && (op_word.command == tss_pkg::CMD_TRANSMIT
                   || op_word.command == tss_pkg::CMD_SEND_SYN
                   || op_word.command == tss_pkg::CMD_SEND_FIN))
      |=> nxt_ff == $past(nxt_ff))
      else $error("send_next moved without a transmit");

   a_una_only_on_ack: assert property (@(posedge clock) disable iff (reset)
      !(op_pop && op_word.command == tss_pkg::CMD_PEER_ACK)
      |=> una_ff == $past(una_ff))
      else $error("oldest unacked moved without a peer ack");

   a_fin_clear_on_ack: assert property (@(posedge clock) disable iff (reset)
      fin_ff && !(op_pop && op_word.command == tss_pkg::CMD_PEER_ACK) |=> fin_ff)
      else $error("fin mark dropped without a peer ack");
`endif

endmodule

/* design/tcp_send_sequence_tracker_top.sv */
// ----------------------------------------------------------------------------
// tcp_send_sequence_tracker_top: send sequence space of one tcp connection
//
//   channel   ports                              word
//   request   req_push, req_full, req_data       tss_req_type, one command
//   result    rsp_pop, rsp_empty, rsp_data       tss_rsp_type, one per command
//   config    csr_we, csr_index, csr_wdata       mss, local port, remote port
//
// One command a cycle while the result queue is not full; a result reaches
// rsp_data through the command queue, which registers the command, and the
// result queue, which registers what the back builds from it.
// The back executes a command in the cycle it leaves the command queue.
// Reset clears the sequence state and loads the register defaults.
// A full result queue stalls the back; the command queue then fills and
// raises req_full.
// ----------------------------------------------------------------------------
module tcp_send_sequence_tracker_top #(
   parameter int SEND_BUFFER_BYTES = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  tss_pkg::tss_req_type            req_data,
   output logic                            req_full,
   input  logic                            rsp_pop,
   output tss_pkg::tss_rsp_type            rsp_data,
   output logic                            rsp_empty,
   input  logic                            csr_we,
   input  logic [tss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int OP_W  = $bits(tss_pkg::tss_op_type);
   localparam int RSP_W = $bits(tss_pkg::tss_rsp_type);

   logic                 op_push, op_full, op_pop, op_empty;
   tss_pkg::tss_op_type  op_in_word, op_out_word;
   logic                 res_push, res_full;
   tss_pkg::tss_rsp_type res_word;

   tss_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .op_push  (op_push),
      .op_word  (op_in_word),
      .op_full  (op_full)
   );

   tss_queue #(.WIDTH(OP_W)) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_in_word),
      .full      (op_full),
      .pop       (op_pop),
      .pop_data  (op_out_word),
      .empty     (op_empty)
   );

   tss_back #(.SEND_BUFFER_BYTES(SEND_BUFFER_BYTES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .op_empty  (op_empty),
      .op_word   (op_out_word),
      .op_pop    (op_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res_word  (res_word)
   );

   tss_queue #(.WIDTH(RSP_W)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_word),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule
